// ===== design/sid_pkg.sv =====
// ----------------------------------------------------------------------------
// sid_pkg
// Shared width constants and the pipeline stage record of the signed divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sid_pkg;

  localparam int unsigned WIDTH = 32;

  // Restoring steps, one per pipeline stage.
  localparam int unsigned STEPS = WIDTH;

  localparam logic [WIDTH-1:0] INT_MIN = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] INT_MAX = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic [WIDTH-1:0] MINUS_ONE = {WIDTH{1'b1}};

  // One slot of the division pipeline. The num field starts as the dividend
  // magnitude and fills up with quotient bits from the bottom as it shifts.
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic             ovf;
    logic             dbz;
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] num;
    logic [WIDTH-1:0] den;
  } sid_stage_t;

endpackage

// ===== design/sid_div_step.sv =====
// ----------------------------------------------------------------------------
// sid_div_step
// One registered restoring-division step: shifts in one dividend bit,
// trial-subtracts the divisor and records one quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sid_div_step
  import sid_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sid_stage_t stage_i,
  output sid_stage_t stage_o
);

  logic [WIDTH:0] trial;
  logic           fits;
  sid_stage_t     stage_d;
  sid_stage_t     stage_q;

  // The shifted remainder stays below twice the divisor, so the top bit of
  // the difference is set exactly when the subtraction borrows.
  assign trial = {stage_i.rem, stage_i.num[WIDTH-1]} - {1'b0, stage_i.den};
  assign fits  = ~trial[WIDTH];

  always_comb begin
    stage_d = stage_i;
    if (fits) begin
      stage_d.rem = trial[WIDTH-1:0];
    end else begin
      stage_d.rem = {stage_i.rem[WIDTH-2:0], stage_i.num[WIDTH-1]};
    end
    stage_d.num = {stage_i.num[WIDTH-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// ===== design/signed_int_divider.sv =====
// ----------------------------------------------------------------------------
// signed_int_divider
// Pipelined signed integer divider, quotient truncated toward zero.
// A result strobes after its start transaction has passed one operand stage,
// one stage per restoring step and one sign/flag stage.
// Throughput: one transaction per cycle; the receiver cannot stall.
// Reset: asynchronous, clears all valid bits; busy is high in reset and until
// the first clock edge after it, then stays low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_int_divider
  import sid_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [WIDTH-1:0] dividend_i,
  input  logic signed [WIDTH-1:0] divisor_i,
  output logic                    valid_o,
  output logic signed [WIDTH-1:0] quotient_o,
  output logic                    overflow_o,
  output logic                    div_by_zero_o
);

  logic             busy_q;
  logic             accept;
  logic [WIDTH-1:0] mag_a;
  logic [WIDTH-1:0] mag_b;
  sid_stage_t       entry_d;
  sid_stage_t       entry_q;
  sid_stage_t       pipe [STEPS+1];

  logic             valid_q;
  logic [WIDTH-1:0] quot_d;
  logic [WIDTH-1:0] quot_q;
  logic             ovf_q;
  logic             dbz_q;

  assign accept = start & ~busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy = busy_q;

  // Operand stage: magnitudes, result sign and the two special cases.
  always_comb begin
    mag_a = dividend_i[WIDTH-1] ? (~$unsigned(dividend_i) + 1'b1) : $unsigned(dividend_i);
    mag_b = divisor_i[WIDTH-1] ? (~$unsigned(divisor_i) + 1'b1) : $unsigned(divisor_i);
    entry_d.valid = accept;
    entry_d.neg   = dividend_i[WIDTH-1] ^ divisor_i[WIDTH-1];
    entry_d.dbz   = ($unsigned(divisor_i) == '0);
    entry_d.ovf   = ($unsigned(dividend_i) == INT_MIN) && ($unsigned(divisor_i) == MINUS_ONE);
    entry_d.rem   = '0;
    entry_d.num   = mag_a;
    entry_d.den   = mag_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign pipe[0] = entry_q;

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    sid_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (pipe[s]),
      .stage_o (pipe[s+1])
    );
  end

  // Output stage: apply the sign, then the flag overrides.
  always_comb begin
    if (pipe[STEPS].dbz) begin
      quot_d = '0;
    end else if (pipe[STEPS].ovf) begin
      quot_d = INT_MAX;
    end else if (pipe[STEPS].neg) begin
      quot_d = ~pipe[STEPS].num + 1'b1;
    end else begin
      quot_d = pipe[STEPS].num;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pipe[STEPS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    ovf_q  <= pipe[STEPS].ovf & ~pipe[STEPS].dbz;
    dbz_q  <= pipe[STEPS].dbz;
  end

  assign valid_o       = valid_q;
  assign quotient_o    = $signed(quot_q);
  assign overflow_o    = ovf_q;
  assign div_by_zero_o = dbz_q;

  // Every accepted transaction strobes exactly once, a fixed time later.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(STEPS + 2) valid_o)
    else $error("accepted transaction does not strobe a result");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, STEPS + 2))
    else $error("result strobe without an accepted transaction");

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(overflow_o && div_by_zero_o))
    else $error("overflow and divide-by-zero both raised");

  a_dbz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && div_by_zero_o) |-> (quot_q == '0))
    else $error("divide-by-zero result is not zero");

  a_ovf_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && overflow_o) |-> (quot_q == INT_MAX))
    else $error("overflow result is not saturated");

endmodule

// ===== bench/signed_int_divider_checker.sv =====
// ----------------------------------------------------------------------------
// signed_int_divider_checker
// Watches the start and result channels of the signed divider. It predicts
// the quotient and flags of each accepted transaction and compares every
// strobed result, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_int_divider_checker
  import sid_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic        [WIDTH-1:0] dividend_i,
  input  logic        [WIDTH-1:0] divisor_i,
  input  logic                    valid_i,
  input  logic        [WIDTH-1:0] quotient_i,
  input  logic                    overflow_i,
  input  logic                    div_by_zero_i,
  output int unsigned             fail_count_o,
  output int unsigned             outstanding_o
);

  typedef struct packed {
    logic [WIDTH-1:0] quotient;
    logic             overflow;
    logic             div_by_zero;
  } division_t;

  division_t   quotients_due [$];
  division_t   want;
  int unsigned fails = 0;

  // Sign handling around an unsigned restoring division of the magnitudes.
  function automatic division_t predict_division(input logic [WIDTH-1:0] num,
                                                 input logic [WIDTH-1:0] den);
    division_t        res;
    logic [WIDTH-1:0] num_mag;
    logic [WIDTH-1:0] den_mag;
    logic [WIDTH-1:0] q;
    logic [WIDTH:0]   part;
    res = '0;
    if (den == '0) begin
      res.div_by_zero = 1'b1;
    end else if (num == INT_MIN && den == MINUS_ONE) begin
      res.quotient = INT_MAX;
      res.overflow = 1'b1;
    end else begin
      // The magnitude of the minimum value is 2^(WIDTH-1), which still fits
      // as an unsigned number.
      num_mag = num[WIDTH-1] ? ~num + 1'b1 : num;
      den_mag = den[WIDTH-1] ? ~den + 1'b1 : den;
      part = '0;
      q    = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
        part = {part[WIDTH-1:0], num_mag[i]};
        if (part >= {1'b0, den_mag}) begin
          part = part - {1'b0, den_mag};
          q[i] = 1'b1;
        end
      end
      res.quotient = (num[WIDTH-1] ^ den[WIDTH-1]) ? ~q + 1'b1 : q;
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Results are retired before new transactions are queued, so a result
      // can never be matched against a prediction made at the same edge.
      if (valid_i) begin
        if (quotients_due.size() == 0) begin
          $error("result with no transaction pending: quotient %0d", $signed(quotient_i));
          fails++;
        end else begin
          want = quotients_due.pop_front();
          if (quotient_i !== want.quotient) begin
            $error("quotient: expected %0d, got %0d",
                   $signed(want.quotient), $signed(quotient_i));
            fails++;
          end
          if (overflow_i !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, overflow_i);
            fails++;
          end
          if (div_by_zero_i !== want.div_by_zero) begin
            $error("div_by_zero: expected %0b, got %0b", want.div_by_zero, div_by_zero_i);
            fails++;
          end
        end
      end
      if (start_i && !busy_i) begin
        quotients_due.push_back(predict_division(dividend_i, divisor_i));
      end
      outstanding_o <= quotients_due.size();
      fail_count_o  <= fails;
    end
  end

endmodule

// ===== bench/signed_int_divider_tb.sv =====
// ----------------------------------------------------------------------------
// signed_int_divider_tb
// Drives the signed divider with directed corner cases and then random
// operand pairs in bursts with random gaps; a checker beside the block
// predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_int_divider_tb
  import sid_pkg::*;
();

  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned NUM_DIRECTED = 23;

  localparam logic signed [WIDTH-1:0] DIRECTED_NUM [NUM_DIRECTED] = '{
    0, INT_MIN, INT_MIN, INT_MIN, INT_MIN, INT_MAX, INT_MAX, INT_MAX,
    7, -7, 7, -7, 1, INT_MAX, INT_MIN, INT_MAX, -1, INT_MIN, INT_MIN,
    0, -1, 5, 3
  };
  localparam logic signed [WIDTH-1:0] DIRECTED_DEN [NUM_DIRECTED] = '{
    0, MINUS_ONE, 1, INT_MIN, INT_MAX, INT_MIN, 1, MINUS_ONE,
    2, 2, -2, -2, INT_MAX, INT_MAX, 0, 0, 0, 2, -2,
    -1, INT_MIN, 5, 7
  };

  logic                    clk_i      = 1'b0;
  logic                    rst_ni     = 1'b0;
  logic                    start      = 1'b0;
  logic signed [WIDTH-1:0] dividend_i = '0;
  logic signed [WIDTH-1:0] divisor_i  = '0;
  logic                    busy;
  logic                    valid_o;
  logic signed [WIDTH-1:0] quotient_o;
  logic                    overflow_o;
  logic                    div_by_zero_o;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;

  signed_int_divider DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .dividend_i    (dividend_i),
    .divisor_i     (divisor_i),
    .valid_o       (valid_o),
    .quotient_o    (quotient_o),
    .overflow_o    (overflow_o),
    .div_by_zero_o (div_by_zero_o)
  );

  signed_int_divider_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .dividend_i    (dividend_i),
    .divisor_i     (divisor_i),
    .valid_i       (valid_o),
    .quotient_i    (quotient_o),
    .overflow_i    (overflow_o),
    .div_by_zero_i (div_by_zero_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("signed_int_divider_tb: done, errors");
    $finish;
  end

  // Leaves start high after the transaction so that back-to-back calls keep
  // the request up without a gap.
  task automatic send_division(input logic [WIDTH-1:0] num, input logic [WIDTH-1:0] den);
    start      <= 1'b1;
    dividend_i <= num;
    divisor_i  <= den;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Operands keep changing while start is low; the block must ignore them.
  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) begin
      @(posedge clk_i);
      dividend_i <= $urandom;
      divisor_i  <= $urandom;
    end
  endtask

  // Mixes full-range values with shortened magnitudes, so that quotients of
  // every length show up, and with the edge values of the range.
  function automatic logic [WIDTH-1:0] random_operand();
    logic [WIDTH-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
      end
      4, 5, 6, 7: begin
        v = v >> $urandom_range(0, WIDTH - 1);
        if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
      end
      8: begin
        case ($urandom_range(0, 4))
          0: v = INT_MIN;
          1: v = INT_MAX;
          2: v = MINUS_ONE;
          3: v = '0;
          default: v = 1;
        endcase
      end
      default: begin
        v = $urandom_range(0, 15);
        if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
      end
    endcase
    return v;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_division(DIRECTED_NUM[i], DIRECTED_DEN[i]);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        case ($urandom_range(0, 49))
          0: send_division(INT_MIN, MINUS_ONE);
          1: send_division(random_operand(), '0);
          default: send_division(random_operand(), random_operand());
        endcase
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        hold_off($urandom_range(1, 8));
      end
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (WIDTH + 4) @(posedge clk_i);

    if (fail_count == 0 && outstanding == 0) begin
      $display("signed_int_divider_tb: done, clean");
    end else begin
      $display("signed_int_divider_tb: done, errors");
    end
    $finish;
  end

endmodule
